[hdl/assert_macros.svh]
// Assertion helpers for the run queue RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante at an edge implies cons at a later edge
`define ASSERT_AFTER2(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

[hdl/drq_pkg.sv]
// Shared types and constants of the deduplicating run queue.
// No dependencies.
`timescale 1ns / 1ps

package drq_pkg;

    localparam int NUM_TASKS_DEF = 64;  // default slot count
    localparam int ID_W          = 6;   // task id field width
    localparam int WORD_W        = 32;  // entry point / argument width

    typedef enum logic
    {
        ACT_SCHEDULE = 1'b0,
        ACT_DISPATCH = 1'b1
    } action_t;

endpackage

[hdl/drq_if.sv]
// Request and result channel interfaces of the run queue.
// Depends on drq_pkg.
`timescale 1ns / 1ps

interface drq_req_if;
    logic                           valid;
    logic                           ready;
    drq_pkg::action_t               action;
    logic [drq_pkg::ID_W-1:0]       task_id;
    logic [drq_pkg::WORD_W-1:0]     entry_point;
    logic [drq_pkg::WORD_W-1:0]     action_argument;

    modport source (output valid, action, task_id, entry_point, action_argument,
                    input ready);
    modport sink   (input valid, action, task_id, entry_point, action_argument,
                    output ready);
endinterface

interface drq_res_if;
    logic                           valid;
    logic                           ready;
    logic                           empty_res;
    logic [drq_pkg::ID_W-1:0]       out_task_id;
    logic [drq_pkg::WORD_W-1:0]     out_entry_point;
    logic [drq_pkg::WORD_W-1:0]     out_argument;

    modport source (output valid, empty_res, out_task_id, out_entry_point, out_argument,
                    input ready);
    modport sink   (input valid, empty_res, out_task_id, out_entry_point, out_argument,
                    output ready);
endinterface

[hdl/dedup_run_queue_unit.sv]
// Deduplicating FIFO run queue, one slot per task. A schedule request stores the
// entry point and argument in the task's slot and, unless the task is already
// pending, appends it at the tail; a pending task keeps its place and only its
// words are replaced. A dispatch request pops the head and returns id, entry point
// and argument (empty_res = 1 with zero fields when nothing is pending); schedule
// requests return nothing, out-of-range task ids are dropped. Slot words, pending
// marks and forward links sit in three synchronous memories with registered reads;
// every request is a read followed by a write-back, and the core takes no new
// request until the write-back is done (a dispatch waits longer while the result
// register is still held by the consumer; an out-of-range schedule has no write-back).
// The result register lets the next request in while a result waits. After reset a
// clearing pass writes all pending marks to zero, with req.ready low.
// Depends on drq_pkg, drq_if.sv and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dedup_run_queue_unit #(
    parameter int NUM_TASKS = drq_pkg::NUM_TASKS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    drq_req_if.sink   req,
    drq_res_if.source res
);

    localparam int IDX_W  = $clog2(NUM_TASKS);
    localparam int ID_W   = drq_pkg::ID_W;
    localparam int WORD_W = drq_pkg::WORD_W;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR = 4'b0001,   // sweep of pending marks after reset
        ST_IDLE  = 4'b0010,   // takes a request, issues memory reads
        ST_SCHED = 4'b0100,   // pending mark read back, link the task
        ST_DISP  = 4'b1000    // head words read back, pop and present
    } state_t;

    // ---------------------------------------------------------------
    // Control and payload registers
    // ---------------------------------------------------------------
    state_t              state_reg,     state_next;
    idx_t                clr_cnt_reg,   clr_cnt_next;
    idx_t                head_reg,      head_next;
    idx_t                tail_reg,      tail_next;
    logic                nonempty_reg,  nonempty_next;
    idx_t                task_reg,      task_next;      // task under schedule
    logic                empty_hit_reg, empty_hit_next; // dispatch saw empty queue

    logic                out_valid_reg, out_valid_next;
    logic                out_empty_reg, out_empty_next;
    logic [ID_W-1:0]     out_id_reg,    out_id_next;
    logic [WORD_W-1:0]   out_ep_reg,    out_ep_next;
    logic [WORD_W-1:0]   out_arg_reg,   out_arg_next;

    // ---------------------------------------------------------------
    // Memories: slot words, pending marks, forward links
    // ---------------------------------------------------------------
    logic [2*WORD_W-1:0] data_mem [NUM_TASKS];
    logic                pend_mem [NUM_TASKS];
    idx_t                link_mem [NUM_TASKS];

    logic [2*WORD_W-1:0] data_rd_reg;
    logic                pend_rd_reg;
    idx_t                link_rd_reg;

    logic                accept;
    logic                in_range;
    idx_t                in_task;
    logic                data_we;   // also the pending-mark read enable
    logic                head_re;   // data and link read at head
    logic                pend_we;
    idx_t                pend_waddr;
    logic                pend_wdata;
    logic                link_we;
    logic                out_free;

    assign accept   = req.valid && req.ready;
    assign in_range = 32'(req.task_id) < NUM_TASKS;
    assign in_task  = IDX_W'(req.task_id);
    assign data_we  = accept && (req.action == drq_pkg::ACT_SCHEDULE) && in_range;
    assign head_re  = accept && (req.action == drq_pkg::ACT_DISPATCH) && nonempty_reg;
    assign out_free = !out_valid_reg || res.ready;

    // slot words are written on acceptance, whether or not the task is pending
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[in_task] <= {req.entry_point, req.action_argument};
        end
        if (head_re)
        begin
            data_rd_reg <= data_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        if (data_we)
        begin
            pend_rd_reg <= pend_mem[in_task];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[tail_reg] <= task_reg;
        end
        if (head_re)
        begin
            link_rd_reg <= link_mem[head_reg];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        nonempty_next  = nonempty_reg;
        task_next      = task_reg;
        empty_hit_next = empty_hit_reg;

        out_valid_next = out_valid_reg && !res.ready;
        out_empty_next = out_empty_reg;
        out_id_next    = out_id_reg;
        out_ep_next    = out_ep_reg;
        out_arg_next   = out_arg_reg;

        pend_we    = 1'b0;
        pend_waddr = clr_cnt_reg;
        pend_wdata = 1'b0;
        link_we    = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                pend_we      = 1'b1;
                clr_cnt_next = clr_cnt_reg + idx_t'(1);
                if (clr_cnt_reg == idx_t'(NUM_TASKS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == drq_pkg::ACT_DISPATCH)
                    begin
                        empty_hit_next = !nonempty_reg;
                        state_next     = ST_DISP;
                    end
                    else if (in_range)
                    begin
                        task_next  = in_task;
                        state_next = ST_SCHED;
                    end
                end
            end

            ST_SCHED:
            begin
                if (!pend_rd_reg)
                begin
                    pend_we    = 1'b1;
                    pend_waddr = task_reg;
                    pend_wdata = 1'b1;
                    tail_next  = task_reg;
                    if (nonempty_reg)
                    begin
                        link_we = 1'b1;
                    end
                    else
                    begin
                        head_next     = task_reg;
                        nonempty_next = 1'b1;
                    end
                end
                state_next = ST_IDLE;
            end

            ST_DISP:
            begin
                // wait here while the consumer still holds the last result
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_empty_next = empty_hit_reg;
                    if (empty_hit_reg)
                    begin
                        out_id_next  = '0;
                        out_ep_next  = '0;
                        out_arg_next = '0;
                    end
                    else
                    begin
                        out_id_next  = ID_W'(head_reg);
                        out_ep_next  = data_rd_reg[2*WORD_W-1:WORD_W];
                        out_arg_next = data_rd_reg[WORD_W-1:0];
                        pend_we      = 1'b1;
                        pend_waddr   = head_reg;
                        pend_wdata   = 1'b0;
                        if (head_reg == tail_reg)
                        begin
                            nonempty_next = 1'b0;
                            head_next     = '0;
                            tail_next     = '0;
                        end
                        else
                        begin
                            head_next = link_rd_reg;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            nonempty_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg      <= task_next;
        empty_hit_reg <= empty_hit_next;
        out_empty_reg <= out_empty_next;
        out_id_reg    <= out_id_next;
        out_ep_reg    <= out_ep_next;
        out_arg_reg   <= out_arg_next;
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign req.ready           = (state_reg == ST_IDLE);
    assign res.valid           = out_valid_reg;
    assign res.empty_res       = out_empty_reg;
    assign res.out_task_id     = out_id_reg;
    assign res.out_entry_point = out_ep_reg;
    assign res.out_argument    = out_arg_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_ALWAYS(a_empty_ptrs_zero, nonempty_reg || (head_reg == '0 && tail_reg == '0), "empty queue with nonzero head or tail")
    `ASSERT_IMPLIES(a_empty_res_zero, res.valid && res.empty_res, res.out_task_id == '0 && res.out_entry_point == '0 && res.out_argument == '0, "empty result carries nonzero fields")
    `ASSERT_AFTER2(a_sched_fills, data_we, nonempty_reg, "queue empty after an in-range schedule")
    `ASSERT_IMPLIES(a_no_read_in_clear, state_reg == ST_CLEAR, !data_we && !head_re && !link_we, "slot access during clearing pass")

endmodule

[tb/sv/tb_dedup_run_queue_unit.sv]
// Testbench for dedup_run_queue_unit: directed and random schedule/dispatch requests
// with random idling on both channels, checked against a mirror of the run queue.
// Depends on drq_pkg and the channel interfaces in drq_if.sv.
`timescale 1ns / 1ps

typedef struct {
    logic                         empty_res;
    logic [drq_pkg::ID_W-1:0]     task_id;
    logic [drq_pkg::WORD_W-1:0]   entry_point;
    logic [drq_pkg::WORD_W-1:0]   argument;
} dispatch_rec_t;

// Mirror of the queue state; every dispatch request queues the result it must produce.
class run_queue_mirror;
    logic [drq_pkg::WORD_W-1:0] entry_mem [drq_pkg::NUM_TASKS_DEF];
    logic [drq_pkg::WORD_W-1:0] arg_mem [drq_pkg::NUM_TASKS_DEF];
    bit                         pending [drq_pkg::NUM_TASKS_DEF];
    logic [drq_pkg::ID_W-1:0]   link [drq_pkg::NUM_TASKS_DEF];
    logic [drq_pkg::ID_W-1:0]   head;
    logic [drq_pkg::ID_W-1:0]   tail;
    bit                         occupied;
    dispatch_rec_t              due_dispatches[$];
    int                         errors;
    int                         n_sched;
    int                         n_resched;
    int                         n_disp;
    int                         n_empty;

    function new();
        foreach (pending[i])
            pending[i] = 1'b0;
        head     = '0;
        tail     = '0;
        occupied = 1'b0;
    endfunction

    function void note_request(drq_pkg::action_t act, logic [drq_pkg::ID_W-1:0] t,
                               logic [drq_pkg::WORD_W-1:0] ep,
                               logic [drq_pkg::WORD_W-1:0] arg);
        dispatch_rec_t r;
        if (act == drq_pkg::ACT_SCHEDULE)
        begin
            if (int'(t) >= drq_pkg::NUM_TASKS_DEF)
                return;
            n_sched++;
            entry_mem[t] = ep;
            arg_mem[t]   = arg;
            // already queued: words replaced, position kept
            if (pending[t])
            begin
                n_resched++;
                return;
            end
            pending[t] = 1'b1;
            if (occupied)
            begin
                link[tail] = t;
                tail       = t;
            end
            else
            begin
                head     = t;
                tail     = t;
                occupied = 1'b1;
            end
        end
        else
        begin
            n_disp++;
            if (!occupied)
            begin
                n_empty++;
                r.empty_res   = 1'b1;
                r.task_id     = '0;
                r.entry_point = '0;
                r.argument    = '0;
            end
            else
            begin
                r.empty_res   = 1'b0;
                r.task_id     = head;
                r.entry_point = entry_mem[head];
                r.argument    = arg_mem[head];
                pending[head] = 1'b0;
                if (head == tail)
                begin
                    occupied = 1'b0;
                    head     = '0;
                    tail     = '0;
                end
                else
                    head = link[head];
            end
            due_dispatches.push_back(r);
        end
    endfunction

    function void compare_field(string name, logic [drq_pkg::WORD_W-1:0] want,
                                logic [drq_pkg::WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_dispatch(logic e, logic [drq_pkg::ID_W-1:0] id,
                                 logic [drq_pkg::WORD_W-1:0] ep,
                                 logic [drq_pkg::WORD_W-1:0] arg);
        dispatch_rec_t want;
        if (due_dispatches.size() == 0)
        begin
            $error("dispatch result with no dispatch request outstanding");
            errors++;
            return;
        end
        want = due_dispatches.pop_front();
        compare_field("empty_res", want.empty_res, e);
        compare_field("out_task_id", want.task_id, id);
        compare_field("out_entry_point", want.entry_point, ep);
        compare_field("out_argument", want.argument, arg);
    endfunction
endclass

module tb_dedup_run_queue_unit;

    localparam int ID_W      = drq_pkg::ID_W;
    localparam int WORD_W    = drq_pkg::WORD_W;
    localparam int NUM_TASKS = drq_pkg::NUM_TASKS_DEF;

    // Cycles without any handshake before the run is declared hung. The slowest
    // legit stretch is reset plus the pending-mark clearing pass, or the longest
    // sender gap plus core latency plus the longest result stall.
    localparam int IDLE_LIMIT   = 2000;
    // Settling time after the last result.
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_REQS  = 900;

    logic clk;
    logic rst_n;

    drq_req_if req_ch();
    drq_res_if res_ch();

    run_queue_mirror queue_mirror;

    int idle_cycles = 0;
    bit req_quiet   = 1'b0;   // sender runs back to back while set
    bit res_quiet   = 1'b0;   // receiver never stalls while set

    dedup_run_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Handshake monitor: both channels sampled at the edge, before NBA updates.
    // The request is noted first so that its own state is in place; a result can
    // never belong to a request accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            queue_mirror.note_request(req_ch.action, req_ch.task_id, req_ch.entry_point,
                                      req_ch.action_argument);
        if (rst_n && res_ch.valid && res_ch.ready)
            queue_mirror.check_dispatch(res_ch.empty_res, res_ch.out_task_id,
                                        res_ch.out_entry_point, res_ch.out_argument);
    end

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: a fresh stall per result, with stretches of no stalling.
    initial
    begin : result_sink
        int stall;
        int served;
        served       = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            if (served % 32 == 0)
                res_quiet = ($urandom_range(3, 0) == 0);
            stall = res_quiet ? 0 : $urandom_range(16, 0);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (res_ch.valid !== 1'b1)
                @(posedge clk);
            served++;
        end
    end

    // Present one request after a random gap and hold it until accepted.
    // Called at a rising edge; returns at the edge that took the request.
    // With no gap valid stays high and only the payload changes.
    task automatic send_request(drq_pkg::action_t act, logic [ID_W-1:0] t,
                                logic [WORD_W-1:0] ep, logic [WORD_W-1:0] arg);
        int gap;
        gap = req_quiet ? 0 : $urandom_range(16, 0);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.action          <= act;
        req_ch.task_id         <= t;
        req_ch.entry_point     <= ep;
        req_ch.action_argument <= arg;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic schedule_task(int t, logic [WORD_W-1:0] ep, logic [WORD_W-1:0] arg);
        send_request(drq_pkg::ACT_SCHEDULE, t[ID_W-1:0], ep, arg);
    endtask

    // Dispatch carries random junk in the fields it ignores.
    task automatic dispatch_next();
        send_request(drq_pkg::ACT_DISPATCH, ID_W'($urandom), $urandom, $urandom);
    endtask

    // Drop valid and hold off until every dispatch has been answered.
    // The check follows a clock edge, so valid is never lowered and raised
    // in the same step.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (queue_mirror.due_dispatches.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int sent;
        int burst_len;
        int pool_lo;
        int pool_n;
        int sched_pct;
        int pick;
        int swap;
        int order [NUM_TASKS];
        bit paused;

        queue_mirror           = new();
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.action          = drq_pkg::ACT_SCHEDULE;
        req_ch.task_id         = '0;
        req_ch.entry_point     = '0;
        req_ch.action_argument = '0;
        sent                   = 0;
        paused                 = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // dispatch straight after reset: empty queue, ignored fields all ones
        send_request(drq_pkg::ACT_DISPATCH, '1, '1, '1);
        schedule_task(0, 32'h0000_0000, 32'h0000_0000);
        schedule_task(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // head already pending: words replaced, stays at the head
        schedule_task(0, 32'hAAAA_AAAA, 32'h5555_5555);
        schedule_task(21, 32'h5555_5555, 32'hAAAA_AAAA);
        dispatch_next();                                   // task 0, latest words
        // popped task scheduled again: goes to the tail this time
        schedule_task(0, 32'h0000_0001, 32'h8000_0000);
        // pending task in the middle of the queue
        schedule_task(21, 32'h1234_5678, 32'h9ABC_DEF0);
        // pending tail
        schedule_task(0, 32'hDEAD_BEEF, 32'h0F0F_F0F0);
        dispatch_next();                                   // 63
        dispatch_next();                                   // 21
        dispatch_next();                                   // 0, last entry
        dispatch_next();                                   // empty
        dispatch_next();                                   // still empty
        // single-entry queue, head equals tail
        schedule_task(42, 32'h8000_0000, 32'h0000_0001);
        dispatch_next();
        // relink the same task after the queue ran dry
        schedule_task(42, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
        schedule_task(42, 32'hFFFF_FFFE, 32'h7FFF_FFFF);
        dispatch_next();
        dispatch_next();

        // sender holds off until all answers are back
        wait_drained();

        // ---- full sweep: every slot queued once, in shuffled order, then drained ----
        foreach (order[i])
            order[i] = i;
        for (int i = NUM_TASKS - 1; i > 0; i--)
        begin
            pick        = $urandom_range(i, 0);
            swap        = order[i];
            order[i]    = order[pick];
            order[pick] = swap;
        end
        foreach (order[i])
        begin
            schedule_task(order[i], $urandom, $urandom);
            sent++;
        end
        // a few rewrites of pending tasks while the queue is full
        repeat (8)
        begin
            schedule_task($urandom_range(NUM_TASKS - 1, 0), $urandom, $urandom);
            sent++;
        end
        repeat (NUM_TASKS + 2)
        begin
            dispatch_next();
            sent++;
        end

        // ---- random bursts ----
        // Each burst works on a pool of task ids (mostly small pools so that
        // rewrites of pending tasks are frequent) with its own schedule/dispatch
        // mix: schedule-heavy bursts fill the queue, dispatch-heavy ones drain
        // it and hit the empty case.
        while (sent < RANDOM_REQS)
        begin
            burst_len = $urandom_range(40, 10);
            pool_lo   = $urandom_range(NUM_TASKS - 1, 0);
            pool_n    = ($urandom_range(3, 0) == 0) ? NUM_TASKS : $urandom_range(8, 1);
            case ($urandom_range(3, 0))
                0:       sched_pct = 25;
                1:       sched_pct = 50;
                2:       sched_pct = 65;
                default: sched_pct = 85;
            endcase
            req_quiet = ($urandom_range(3, 0) == 0);
            repeat (burst_len)
            begin
                if ($urandom_range(99, 0) < sched_pct)
                    schedule_task((pool_lo + $urandom_range(pool_n - 1, 0)) % NUM_TASKS,
                                  $urandom, $urandom);
                else
                    dispatch_next();
                sent++;
            end
            if (!paused && sent > RANDOM_REQS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
        req_quiet = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d schedule requests, %0d of them rewriting a pending task",
                 queue_mirror.n_sched, queue_mirror.n_resched);
        $display("covered %0d dispatch requests, %0d of them on an empty queue",
                 queue_mirror.n_disp, queue_mirror.n_empty);
        if (queue_mirror.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/drq_pkg.sv
hdl/drq_if.sv
hdl/dedup_run_queue_unit.sv
tb/sv/tb_dedup_run_queue_unit.sv
